@@ rtl/tpdc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpdc_pkg
// shared types, codes and constants of the tester pin driver control block
// ----------------------------------------------------------------------------
package tpdc_pkg;

    localparam int PIN_COUNT      = 36;
    localparam int SIG_COUNT      = 30;   // non-power pins
    localparam int LEVEL_BOARDS   = 15;   // level shifter boards 0..14
    localparam int IN_TDATA_W     = 56;
    localparam int OUT_TDATA_W    = 24;

    localparam logic [3:0] LOAD_BOARD_NUM   = 4'd15;
    localparam logic [7:0] MAX_LOAD_CURRENT = 8'd127;
    localparam logic [7:0] LEVEL_INVERT     = 8'hF0;
    localparam logic [7:0] LOAD_INVERT      = 8'h3F;

    typedef enum logic [2:0] {
        CMD_SETFUNC  = 3'd0,
        CMD_MEASURE  = 3'd1,
        CMD_PULLDOWN = 3'd2,
        CMD_DATAOUT  = 3'd3,
        CMD_GROUND   = 3'd4,
        CMD_GETVALUE = 3'd5,
        CMD_GETFUNC  = 3'd6,
        CMD_LOADCUR  = 3'd7
    } t_cmd;

    localparam logic [2:0] FN_POWER    = 3'd0;
    localparam logic [2:0] FN_GND      = 3'd1;
    localparam logic [2:0] FN_INPUT    = 3'd2;
    localparam logic [2:0] FN_OUTPUT   = 3'd3;
    localparam logic [2:0] FN_DISABLED = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PIN   = 2'd1;
    localparam logic [1:0] ST_REFUSED   = 2'd2;
    localparam logic [1:0] ST_BAD_CUR   = 2'd3;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // run the command, update state, load result register
    } t_ctrl;

endpackage

@@ rtl/tpdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpdc_ctrl
// handshake controller: accepts a beat, runs it, holds the result beat
// ----------------------------------------------------------------------------
module tpdc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output tpdc_pkg::t_ctrl o_ctrl
);
    import tpdc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_ctrl      = '0;
        s_ready     = 1'b0;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                // result register is free by the time the exec cycle writes it
                s_ready = !r_out_valid || i_m_axis_tready;
                if (s_ready && i_s_axis_tvalid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;

endmodule

@@ rtl/tpdc_datapath.sv @@
// ----------------------------------------------------------------------------
// tpdc_datapath
// pin decode, mode and board shadow registers, command execution
// ----------------------------------------------------------------------------
module tpdc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tpdc_pkg::t_ctrl                     i_ctrl,
    input  logic [tpdc_pkg::IN_TDATA_W-1:0]     i_tdata,
    output logic [tpdc_pkg::OUT_TDATA_W-1:0]    o_tdata
);
    import tpdc_pkg::*;

    // captured input beat
    logic [2:0]  r_cmd;
    logic [5:0]  r_pin;
    logic [2:0]  r_fn;
    logic        r_flag;
    logic [7:0]  r_cur;
    logic [31:0] r_samp;

    // state
    logic [2:0]  r_mode   [SIG_COUNT];
    logic [7:0]  r_shadow [LEVEL_BOARDS];

    // result register
    logic [OUT_TDATA_W-1:0] r_out;

    // decode
    logic        pin_ok, pwr;
    logic [4:0]  k;
    logic [3:0]  bd;
    logic        slot2;
    logic [2:0]  mode;
    logic [7:0]  sh;
    logic        b_meas, b_pin, b_pd, b_do;
    logic        ok, wr;
    logic [7:0]  new_byte;
    logic [7:0]  load_byte;
    logic [1:0]  n_status;
    logic        n_wv;
    logic [3:0]  n_addr;
    logic [7:0]  n_byte;
    logic        n_pval;
    logic [2:0]  n_pfn;
    logic        mode_wr;

    always_comb begin
        pin_ok = r_pin < 6'(PIN_COUNT);
        pwr    = (r_pin <= 6'd2) || (r_pin >= 6'd18 && r_pin <= 6'd20);
        if (pwr || !pin_ok) begin
            k = 5'd0;
        end else if (r_pin < 6'd18) begin
            k = 5'(r_pin - 6'd3);
        end else begin
            k = 5'(r_pin - 6'd6);
        end
        bd    = k[4:1];
        slot2 = k[0];
        mode  = pwr ? FN_POWER : r_mode[k];
        sh    = r_shadow[bd];

        // current bits of this slot
        b_meas = slot2 ? sh[1] : sh[0];
        b_pin  = slot2 ? sh[3] : sh[2];
        b_pd   = slot2 ? sh[6] : sh[4];
        b_do   = slot2 ? sh[7] : sh[5];

        ok      = 1'b0;
        wr      = 1'b1;
        mode_wr = 1'b0;
        n_pval  = 1'b0;
        n_pfn   = 3'd0;

        case (t_cmd'(r_cmd))
            CMD_SETFUNC: begin
                ok = !pwr && mode != FN_POWER && r_fn >= FN_GND && r_fn <= FN_DISABLED;
                b_pin = (r_fn == FN_INPUT) || (r_fn == FN_OUTPUT);
                if (r_fn == FN_GND) begin
                    b_pin = 1'b1;
                    b_do  = 1'b1;
                    b_pd  = 1'b0;
                end else if (r_fn == FN_DISABLED) begin
                    b_do = 1'b0;
                    b_pd = 1'b0;
                end
                mode_wr = ok;
            end
            CMD_MEASURE: begin
                ok     = !pwr && mode != FN_POWER && mode != FN_GND;
                b_meas = r_flag;
            end
            CMD_PULLDOWN: begin
                ok   = !pwr && mode == FN_INPUT;
                b_pd = r_flag;
            end
            CMD_DATAOUT: begin
                ok   = !pwr && mode == FN_OUTPUT;
                b_do = !r_flag;
                b_pd = r_flag;
            end
            CMD_GROUND: begin
                ok   = !pwr && mode != FN_POWER;
                b_do = r_flag;
            end
            CMD_GETVALUE: begin
                wr = 1'b0;
                ok = !pwr && (mode == FN_INPUT || mode == FN_OUTPUT);
                if (ok) begin
                    n_pval = r_samp[k ^ 5'd1];
                end
            end
            CMD_GETFUNC: begin
                wr    = 1'b0;
                ok    = 1'b1;
                n_pfn = mode;
            end
            default: begin
                wr = 1'b0;   // load current handled below
            end
        endcase

        new_byte = sh;
        if (slot2) begin
            new_byte[1] = b_meas;
            new_byte[3] = b_pin;
            new_byte[6] = b_pd;
            new_byte[7] = b_do;
        end else begin
            new_byte[0] = b_meas;
            new_byte[2] = b_pin;
            new_byte[4] = b_pd;
            new_byte[5] = b_do;
        end

        load_byte = {1'b0, (r_cur != 8'd0), r_cur[6:1]};

        n_status = ST_OK;
        n_wv     = 1'b0;
        n_addr   = 4'd0;
        n_byte   = 8'd0;
        if (t_cmd'(r_cmd) == CMD_LOADCUR) begin
            n_pval = 1'b0;
            n_pfn  = 3'd0;
            if (r_cur > MAX_LOAD_CURRENT) begin
                n_status = ST_BAD_CUR;
            end else begin
                n_wv   = 1'b1;
                n_addr = LOAD_BOARD_NUM;
                n_byte = load_byte ^ LOAD_INVERT;
            end
        end else if (!pin_ok) begin
            n_status = ST_BAD_PIN;
            n_pval   = 1'b0;
            n_pfn    = 3'd0;
            mode_wr  = 1'b0;
        end else if (!ok) begin
            n_status = ST_REFUSED;
            n_pval   = 1'b0;
            n_pfn    = 3'd0;
        end else if (wr) begin
            n_wv   = 1'b1;
            n_addr = bd;
            n_byte = new_byte ^ LEVEL_INVERT;
        end
    end

    // input capture and result register, no reset on either
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_tdata[2:0];
            r_pin  <= i_tdata[8:3];
            r_fn   <= i_tdata[11:9];
            r_flag <= i_tdata[12];
            r_cur  <= i_tdata[20:13];
            r_samp <= i_tdata[52:21];
        end
        if (i_ctrl.exec) begin
            r_out <= {5'd0, n_pfn, n_pval, n_byte, n_addr, n_wv, n_status};
        end
    end

    // pin modes and board shadows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIG_COUNT; i++) begin
                r_mode[i] <= FN_DISABLED;
            end
            for (int i = 0; i < LEVEL_BOARDS; i++) begin
                r_shadow[i] <= 8'd0;
            end
        end else if (i_ctrl.exec) begin
            if (mode_wr) begin
                r_mode[k] <= r_fn;
            end
            if (n_wv && t_cmd'(r_cmd) != CMD_LOADCUR) begin
                r_shadow[bd] <= new_byte;
            end
        end
    end

    assign o_tdata = r_out;

endmodule

@@ rtl/tester_pin_driver_control.sv @@
// ----------------------------------------------------------------------------
// tester_pin_driver_control
// command front end for 36 tester pins on 15 level boards and one load board
// ----------------------------------------------------------------------------
// a command beat is captured, then run in the execute state of the controller,
//   and the result beat is registered with its valid flag; no new command
//   is taken during execution, and the result register frees up as it is drained
// reset (i_rst_n low, synchronous): board shadows cleared, non-power pins
//   set to disabled, no result pending, ready in the first cycle after reset
// ----------------------------------------------------------------------------
module tester_pin_driver_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command beat
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] command, [8:3] pin_index, [11:9] function_code, [12] flag,
    // [20:13] load_current, [52:21] sampled_inputs, [55:53] zero
    input  logic [55:0] i_s_axis_tdata,
    // result beat
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [2] write_valid, [6:3] board_address, [14:7] board_byte,
    // [15] pin_value, [18:16] pin_function, [23:19] zero
    output logic [23:0] o_m_axis_tdata
);
    import tpdc_pkg::*;

    // command strobes from the controller to the datapath
    t_ctrl ctrl;

    // controller: owns both handshakes and the result valid flag
    tpdc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_ctrl          (ctrl)
    );

    // datapath: pin decode, function checks, shadow read-modify-write,
    // bus polarity inversion and the result register
    tpdc_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_tdata (i_s_axis_tdata),
        .o_tdata (o_m_axis_tdata)
    );

endmodule
